FILE: rtl/core/l1td_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// l1td_pkg
// Shared types, register map, trigger mode codes and constants of the
// level-1 trigger decision unit.
// ---------------------------------------------------------------------------
package l1td_pkg;

    // Register map: word index taken from paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_MIN_TOF_PLANES  = 3'd0;
    localparam logic [2:0] REG_MAX_ANTI_HITS   = 3'd1;
    localparam logic [2:0] REG_TRIGGER_MODE    = 3'd2;
    localparam logic [2:0] REG_MAX_SCALER_RATE = 3'd3;
    localparam logic [2:0] REG_MIN_LIFETIME    = 3'd4;
    localparam logic [2:0] REG_REAL_DATA_MODE  = 3'd5;
    localparam logic [2:0] REG_BEAM_TEST_MODE  = 3'd6;

    // Final trigger selection codes; anything above MODE_TOF_OR_CALO is an error
    typedef enum logic [3:0] {
        MODE_UNIVERSAL    = 4'd0,
        MODE_TOF          = 4'd1,
        MODE_CALO         = 4'd2,
        MODE_TOF_AND_CALO = 4'd3,
        MODE_CHARGE_ONE   = 4'd4,
        MODE_CHARGE_TWO   = 4'd5,
        MODE_ELECTRON     = 4'd6,
        MODE_PHOTON       = 4'd7,
        MODE_TOF_OR_CALO  = 4'd8
    } trig_mode_t;

    // Configuration register contents
    typedef struct packed {
        logic [2:0]  min_tof_planes;
        logic [7:0]  max_anti_hits;
        logic [3:0]  trigger_mode;
        logic [23:0] max_scaler_rate;
        logic [11:0] min_lifetime;
        logic        real_data_mode;
        logic        beam_test_mode;
    } cfg_t;

    // Event constants
    localparam logic [6:0]  CALO_PHOTON_FLAG = 7'd13;
    localparam logic [6:0]  TOF_CHARGE_TWO   = 7'd2;
    localparam logic [3:0]  CALO_ELEC_LEVEL  = 4'd2;
    localparam logic [11:0] LIFETIME_ONE     = 12'd1000;
    localparam int unsigned PLANES_CARRIED   = 4;
    localparam int unsigned PLANE_W          = 16;

    // Mode word arithmetic: temperature * 10000 plus live time, 22-bit signed
    localparam int unsigned   MODE_SUM_W  = 22;
    localparam logic signed [MODE_SUM_W-1:0] TEMP_SCALE = 22'sd10000;
    localparam logic signed [MODE_SUM_W-1:0] MODE_MAX   = 22'sd1048575;
    localparam logic signed [MODE_SUM_W-1:0] MODE_MIN   = -22'sd1048576;

    // Units digit of a 7-bit flag: reciprocal multiply by 205/2048, exact for every 7-bit value
    function automatic logic [3:0] units_digit(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  quo;
        logic [6:0]  tens;
        prod = {8'd0, v} * 15'd205;
        quo  = prod[14:11];
        tens = {3'd0, quo} * 7'd10;
        return 4'(v - tens);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/level1_trigger_decision_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// level1_trigger_decision_unit
// Level-1 trigger decision for one detector event per transaction.
// ---------------------------------------------------------------------------
// The unit takes one event at every clock edge where start is high (busy is
// always low) and returns exactly one result for it, marked by a single-cycle
// done strobe; the receiver cannot stall it, so results must be captured in
// the cycle they appear. It has three register stages: flag classification
// and the temperature multiply, trigger selection and the mode-word add, then
// saturation and record gating into the output registers. Record fields read
// zero when accepted is low. The user writes configuration over the APB-style
// port only while no event is in flight; the unit does not enforce this.
module level1_trigger_decision_unit
#(
    parameter int unsigned NUM_PLANES = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // event command
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [6:0]         tof_flag,
    input  wire logic [15:0]        plane0_hits,
    input  wire logic [15:0]        plane1_hits,
    input  wire logic [15:0]        plane2_hits,
    input  wire logic [15:0]        plane3_hits,
    input  wire logic [31:0]        anti_pattern,
    input  wire logic [6:0]         calo_flag,
    input  wire logic [31:0]        calo_sum,
    input  wire logic [23:0]        scaler_sum,
    input  wire logic [11:0]        lifetime_milli,
    input  wire logic signed [7:0]  temperature,
    // result
    output logic                    done,
    output logic                    accepted,
    output logic                    error_mark,
    output logic signed [20:0]      mode_word,
    output logic [6:0]              tof_flag_out,
    output logic [31:0]             plane0_or_and,
    output logic [31:0]             plane1_or_and,
    output logic [31:0]             plane2_or_and,
    output logic [31:0]             plane3_or_and,
    output logic [31:0]             anti_pattern_out,
    output logic [6:0]              calo_flag_out,
    output logic [31:0]             calo_sum_out
);

    localparam int unsigned NP = l1td_pkg::PLANES_CARRIED;
    localparam int unsigned PW = l1td_pkg::PLANE_W;
    localparam int unsigned SW = l1td_pkg::MODE_SUM_W;

    l1td_pkg::cfg_t cfg;

    l1td_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy = 1'b0;

    // -----------------------------------------------------------------------
    // Stage 1: plane count and flag classification
    // -----------------------------------------------------------------------
    logic [PW-1:0] planes_in [NP];
    logic [2:0]    nplanes;
    logic          accept_in;

    assign accept_in    = start & ~busy;
    assign planes_in[0] = plane0_hits;
    assign planes_in[1] = plane1_hits;
    assign planes_in[2] = plane2_hits;
    assign planes_in[3] = plane3_hits;

    // Count planes with hits, ignore planes beyond NUM_PLANES
    always_comb
    begin
        nplanes = 3'd0;
        for (int i = 0; i < NP; i++)
        begin
            if (i < NUM_PLANES && planes_in[i] != '0)
                nplanes = nplanes + 3'd1;
        end
    end

    logic                 s1_valid_reg;
    logic                 s1_tof_ok_reg;
    logic                 s1_anti_ok_reg;
    logic                 s1_ec_ok_reg;
    logic                 s1_tof_z2_reg;
    logic                 s1_elec_lvl_reg;
    logic                 s1_phot_reg;
    logic                 s1_rate_ok_reg;
    logic                 s1_life_ok_reg;
    logic                 s1_life_hi_reg;
    logic signed [SW-1:0] s1_temp_prod_reg;
    logic [11:0]          s1_life_reg;
    logic [6:0]           s1_tof_flag_reg;
    logic [PW-1:0]        s1_planes_reg [NP];
    logic [31:0]          s1_anti_reg;
    logic [6:0]           s1_calo_flag_reg;
    logic [31:0]          s1_calo_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept_in;
    end

    always_ff @(posedge clk)
    begin
        s1_tof_ok_reg    <= (tof_flag != 7'd0) && (nplanes >= cfg.min_tof_planes);
        s1_anti_ok_reg   <= anti_pattern[7:0] <= cfg.max_anti_hits;
        s1_ec_ok_reg     <= calo_flag != 7'd0;
        s1_tof_z2_reg    <= tof_flag > l1td_pkg::TOF_CHARGE_TWO;
        s1_elec_lvl_reg  <= l1td_pkg::units_digit(calo_flag) >= l1td_pkg::CALO_ELEC_LEVEL;
        s1_phot_reg      <= calo_flag == l1td_pkg::CALO_PHOTON_FLAG;
        s1_rate_ok_reg   <= scaler_sum < cfg.max_scaler_rate;
        s1_life_ok_reg   <= lifetime_milli > cfg.min_lifetime;
        s1_life_hi_reg   <= lifetime_milli > l1td_pkg::LIFETIME_ONE;
        s1_temp_prod_reg <= $signed({{(SW-8){temperature[7]}}, temperature})
                            * l1td_pkg::TEMP_SCALE;
        s1_life_reg      <= lifetime_milli;
        s1_tof_flag_reg  <= tof_flag;
        for (int i = 0; i < NP; i++)
            s1_planes_reg[i] <= (i < NUM_PLANES) ? planes_in[i] : '0;
        s1_anti_reg      <= anti_pattern;
        s1_calo_flag_reg <= calo_flag;
        s1_calo_sum_reg  <= calo_sum;
    end

    // -----------------------------------------------------------------------
    // Stage 2: partial triggers, final selection, error marks, mode sum
    // -----------------------------------------------------------------------
    logic trig;
    logic bad_mode;
    logic acc;
    logic err;
    logic z1;
    logic z2;
    logic elec;
    logic uni;

    assign z1   = s1_tof_ok_reg & s1_anti_ok_reg;
    assign z2   = s1_tof_ok_reg & s1_tof_z2_reg;
    assign elec = s1_tof_ok_reg & s1_elec_lvl_reg;
    assign uni  = z1 | z2 | elec | s1_phot_reg;

    // Select the final trigger
    always_comb
    begin
        bad_mode = 1'b0;
        unique case (l1td_pkg::trig_mode_t'(cfg.trigger_mode))
            l1td_pkg::MODE_UNIVERSAL:    trig = uni;
            l1td_pkg::MODE_TOF:          trig = s1_tof_ok_reg;
            l1td_pkg::MODE_CALO:         trig = s1_ec_ok_reg;
            l1td_pkg::MODE_TOF_AND_CALO: trig = s1_tof_ok_reg & s1_ec_ok_reg;
            l1td_pkg::MODE_CHARGE_ONE:   trig = z1;
            l1td_pkg::MODE_CHARGE_TWO:   trig = z2;
            l1td_pkg::MODE_ELECTRON:     trig = elec;
            l1td_pkg::MODE_PHOTON:       trig = s1_phot_reg;
            l1td_pkg::MODE_TOF_OR_CALO:  trig = s1_tof_ok_reg | s1_ec_ok_reg;
            default:
            begin
                trig     = 1'b0;
                bad_mode = 1'b1;
            end
        endcase
    end

    // Keep on low rate or good live time; mark errors
    always_comb
    begin
        acc = trig & (s1_rate_ok_reg | s1_life_ok_reg);
        err = bad_mode
            | (s1_life_hi_reg & ~cfg.beam_test_mode & cfg.real_data_mode)
            | (~acc & cfg.real_data_mode & ~s1_rate_ok_reg & ~s1_life_ok_reg);
    end

    logic                 s2_valid_reg;
    logic                 s2_acc_reg;
    logic                 s2_err_reg;
    logic signed [SW-1:0] s2_mode_sum_reg;
    logic [6:0]           s2_tof_flag_reg;
    logic [PW-1:0]        s2_planes_reg [NP];
    logic [31:0]          s2_anti_reg;
    logic [6:0]           s2_calo_flag_reg;
    logic [31:0]          s2_calo_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_acc_reg       <= acc;
        s2_err_reg       <= err;
        s2_mode_sum_reg  <= $signed({{(SW-12){1'b0}}, s1_life_reg}) + s1_temp_prod_reg;
        s2_tof_flag_reg  <= s1_tof_flag_reg;
        s2_planes_reg    <= s1_planes_reg;
        s2_anti_reg      <= s1_anti_reg;
        s2_calo_flag_reg <= s1_calo_flag_reg;
        s2_calo_sum_reg  <= s1_calo_sum_reg;
    end

    // -----------------------------------------------------------------------
    // Stage 3: saturate the mode word and gate the record into the outputs
    // -----------------------------------------------------------------------
    logic signed [20:0] mode_sat;

    always_comb
    begin
        if (s2_mode_sum_reg > l1td_pkg::MODE_MAX)
            mode_sat = l1td_pkg::MODE_MAX[20:0];
        else if (s2_mode_sum_reg < l1td_pkg::MODE_MIN)
            mode_sat = l1td_pkg::MODE_MIN[20:0];
        else
            mode_sat = s2_mode_sum_reg[20:0];
    end

    logic                done_reg;
    logic                accepted_reg;
    logic                error_mark_reg;
    logic signed [20:0]  mode_word_reg;
    logic [6:0]          tof_flag_out_reg;
    logic [31:0]         plane_or_and_reg [NP];
    logic [31:0]         anti_pattern_out_reg;
    logic [6:0]          calo_flag_out_reg;
    logic [31:0]         calo_sum_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2_valid_reg;
    end

    // Drop the record fields when not accepted
    always_ff @(posedge clk)
    begin
        accepted_reg         <= s2_acc_reg;
        error_mark_reg       <= s2_err_reg;
        mode_word_reg        <= s2_acc_reg ? mode_sat : '0;
        tof_flag_out_reg     <= s2_acc_reg ? s2_tof_flag_reg : '0;
        for (int i = 0; i < NP; i++)
            plane_or_and_reg[i] <= s2_acc_reg ? {s2_planes_reg[i], s2_planes_reg[i]} : '0;
        anti_pattern_out_reg <= s2_acc_reg ? s2_anti_reg : '0;
        calo_flag_out_reg    <= s2_acc_reg ? s2_calo_flag_reg : '0;
        calo_sum_out_reg     <= s2_acc_reg ? s2_calo_sum_reg : '0;
    end

    assign done             = done_reg;
    assign accepted         = accepted_reg;
    assign error_mark       = error_mark_reg;
    assign mode_word        = mode_word_reg;
    assign tof_flag_out     = tof_flag_out_reg;
    assign plane0_or_and    = plane_or_and_reg[0];
    assign plane1_or_and    = plane_or_and_reg[1];
    assign plane2_or_and    = plane_or_and_reg[2];
    assign plane3_or_and    = plane_or_and_reg[3];
    assign anti_pattern_out = anti_pattern_out_reg;
    assign calo_flag_out    = calo_flag_out_reg;
    assign calo_sum_out     = calo_sum_out_reg;

endmodule
`default_nettype wire

FILE: rtl/core/l1td_cfg_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// l1td_cfg_regs
// APB-style register file holding the trigger configuration; writes take
// effect at the access phase, reads return the register contents.
// ---------------------------------------------------------------------------
module l1td_cfg_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [l1td_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output l1td_pkg::cfg_t                   cfg
);

    l1td_pkg::cfg_t cfg_reg;
    l1td_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                l1td_pkg::REG_MIN_TOF_PLANES:  cfg_next.min_tof_planes  = pwdata[2:0];
                l1td_pkg::REG_MAX_ANTI_HITS:   cfg_next.max_anti_hits   = pwdata[7:0];
                l1td_pkg::REG_TRIGGER_MODE:    cfg_next.trigger_mode    = pwdata[3:0];
                l1td_pkg::REG_MAX_SCALER_RATE: cfg_next.max_scaler_rate = pwdata[23:0];
                l1td_pkg::REG_MIN_LIFETIME:    cfg_next.min_lifetime    = pwdata[11:0];
                l1td_pkg::REG_REAL_DATA_MODE:  cfg_next.real_data_mode  = pwdata[0];
                l1td_pkg::REG_BEAM_TEST_MODE:  cfg_next.beam_test_mode  = pwdata[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_tof_planes  <= 3'd3;
            cfg_reg.max_anti_hits   <= 8'd0;
            cfg_reg.trigger_mode    <= 4'd0;
            cfg_reg.max_scaler_rate <= 24'hFFFFFF;
            cfg_reg.min_lifetime    <= 12'd0;
            cfg_reg.real_data_mode  <= 1'b0;
            cfg_reg.beam_test_mode  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            l1td_pkg::REG_MIN_TOF_PLANES:  prdata = {29'd0, cfg_reg.min_tof_planes};
            l1td_pkg::REG_MAX_ANTI_HITS:   prdata = {24'd0, cfg_reg.max_anti_hits};
            l1td_pkg::REG_TRIGGER_MODE:    prdata = {28'd0, cfg_reg.trigger_mode};
            l1td_pkg::REG_MAX_SCALER_RATE: prdata = {8'd0, cfg_reg.max_scaler_rate};
            l1td_pkg::REG_MIN_LIFETIME:    prdata = {20'd0, cfg_reg.min_lifetime};
            l1td_pkg::REG_REAL_DATA_MODE:  prdata = {31'd0, cfg_reg.real_data_mode};
            l1td_pkg::REG_BEAM_TEST_MODE:  prdata = {31'd0, cfg_reg.beam_test_mode};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire
